// ===== hdl/c2s_pkg.sv =====
`timescale 1ns / 1ps

package c2s_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // internal angles are counts of 2^-32 turn
    localparam int TURN_BITS = 32;
    localparam int ATAN_LEN  = 32;

    localparam logic [TURN_BITS-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== hdl/c2s_sqrt_cell.sv =====
`timescale 1ns / 1ps

module c2s_sqrt_cell #(
    parameter int NW = 31
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [2*NW-1:0]      op_in   [2],
    input  logic [NW+1:0]        rem_in  [2],
    input  logic [NW-1:0]        root_in [2],
    input  logic signed [NW-1:0] nx_in,
    input  logic signed [NW-1:0] ny_in,
    input  logic signed [NW-1:0] nz_in,
    output logic [2*NW-1:0]      op_out   [2],
    output logic [NW+1:0]        rem_out  [2],
    output logic [NW-1:0]        root_out [2],
    output logic signed [NW-1:0] nx_out,
    output logic signed [NW-1:0] ny_out,
    output logic signed [NW-1:0] nz_out
);

    logic [2*NW-1:0]      op_reg    [2];
    logic [2*NW-1:0]      op_next   [2];
    logic [NW+1:0]        rem_reg   [2];
    logic [NW+1:0]        rem_next  [2];
    logic [NW-1:0]        root_reg  [2];
    logic [NW-1:0]        root_next [2];
    logic [NW+1:0]        shifted   [2];
    logic [NW+1:0]        trial     [2];
    logic signed [NW-1:0] nx_reg;
    logic signed [NW-1:0] ny_reg;
    logic signed [NW-1:0] nz_reg;

    // one root bit per cell: bring down two operand bits, try (root << 2) | 1
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            shifted[l] = {rem_in[l][NW-1:0], op_in[l][2*NW-1 -: 2]};
            trial[l]   = {root_in[l], 2'b01};
            op_next[l] = {op_in[l][2*NW-3:0], 2'b00};
            if (shifted[l] >= trial[l])
            begin
                rem_next[l]  = shifted[l] - trial[l];
                root_next[l] = {root_in[l][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[l]  = shifted[l];
                root_next[l] = {root_in[l][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            nx_reg   <= nx_in;
            ny_reg   <= ny_in;
            nz_reg   <= nz_in;
        end
    end

    assign op_out   = op_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign nx_out   = nx_reg;
    assign ny_out   = ny_reg;
    assign nz_out   = nz_reg;

endmodule

// ===== hdl/c2s_cordic_cell.sv =====
`timescale 1ns / 1ps

module c2s_cordic_cell #(
    parameter int CWD   = 34,
    parameter int AGW   = 35,
    parameter int STAGE = 0,
    parameter int RW    = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [CWD-1:0] px_in    [2],
    input  logic signed [CWD-1:0] py_in    [2],
    input  logic signed [AGW-1:0] ang_in   [2],
    input  logic                  fixed_in [2],
    input  logic [RW-1:0]         radius_in,
    output logic signed [CWD-1:0] px_out    [2],
    output logic signed [CWD-1:0] py_out    [2],
    output logic signed [AGW-1:0] ang_out   [2],
    output logic                  fixed_out [2],
    output logic [RW-1:0]         radius_out
);

    import c2s_pkg::*;

    localparam logic signed [AGW-1:0] STEP_ANG =
        $signed({{(AGW-TURN_BITS){1'b0}}, ATAN_TURNS[STAGE]});

    logic signed [CWD-1:0] px_reg   [2];
    logic signed [CWD-1:0] px_next  [2];
    logic signed [CWD-1:0] py_reg   [2];
    logic signed [CWD-1:0] py_next  [2];
    logic signed [AGW-1:0] ang_reg  [2];
    logic signed [AGW-1:0] ang_next [2];
    logic signed [CWD-1:0] dx       [2];
    logic signed [CWD-1:0] dy       [2];
    logic                  fixed_reg [2];
    logic [RW-1:0]         radius_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            dx[l] = py_in[l] >>> STAGE;
            dy[l] = px_in[l] >>> STAGE;
            if (fixed_in[l])
            begin
                // axis case settled up front: hold
                px_next[l]  = px_in[l];
                py_next[l]  = py_in[l];
                ang_next[l] = ang_in[l];
            end
            else if (!py_in[l][CWD-1] && (py_in[l] != '0))
            begin
                px_next[l]  = px_in[l] + dx[l];
                py_next[l]  = py_in[l] - dy[l];
                ang_next[l] = ang_in[l] + STEP_ANG;
            end
            else
            begin
                px_next[l]  = px_in[l] - dx[l];
                py_next[l]  = py_in[l] + dy[l];
                ang_next[l] = ang_in[l] - STEP_ANG;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            ang_reg    <= ang_next;
            fixed_reg  <= fixed_in;
            radius_reg <= radius_in;
        end
    end

    assign px_out     = px_reg;
    assign py_out     = py_reg;
    assign ang_out    = ang_reg;
    assign fixed_out  = fixed_reg;
    assign radius_out = radius_reg;

endmodule

// ===== hdl/cartesian_to_spherical_unit.sv =====
`timescale 1ns / 1ps

// Converts one point (coord_x, coord_y, coord_z) per cycle, unless stalled,
// into radius, polar angle and azimuth. The squaring and normalization
// stages are followed by a chain of NW square-root cells, where
// NW = max(COORD_WIDTH, 30) + 1 (one root bit each, radius and xy-length
// side by side), one CORDIC setup stage, one vectoring CORDIC cell per stage
// for both angles, and the output register. The whole chain advances
// together; a two-entry output buffer keeps input requests flowing while a
// result waits, and stalls the input only once both entries are full.

module cartesian_to_spherical_unit #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = c2s_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COORD_WIDTH-1:0]        radius,
    output logic [ANGLE_WIDTH-1:0]        polar_angle,
    output logic [ANGLE_WIDTH-1:0]        azimuth
);

    import c2s_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam int CS    = CORDIC_STAGES;
    localparam int NW    = ((CW > 30) ? CW : 30) + 1;
    localparam int OPW   = 2 * NW;
    localparam int CWD   = NW + 3;
    localparam int AGW   = TURN_BITS + 3;
    localparam int NP    = 6 + NW + CS;
    localparam int SH    = TURN_BITS - AW;
    localparam logic [TURN_BITS:0] RADD = ((TURN_BITS+1)'(1) << SH) >> 1;
    localparam logic signed [AGW-1:0] HALF = AGW'(64'd1 << (TURN_BITS - 1));

    logic          en;
    logic [NP-1:0] v_reg;

    // stage 1: magnitudes and largest magnitude
    logic signed [CW-1:0] p1_x_reg, p1_y_reg, p1_z_reg;
    logic [CW-1:0]        p1_ax_reg, p1_ay_reg, p1_az_reg, p1_m_reg;
    logic [CW-1:0]        ax_next, ay_next, az_next, m_next;
    // stage 2: squares and normalizing shift
    logic signed [CW-1:0] p2_x_reg, p2_y_reg, p2_z_reg;
    logic [2*CW-1:0]      p2_sqx_reg, p2_sqy_reg, p2_sqz_reg;
    logic [4:0]           p2_s_reg, s_next;
    logic [5:0]           msb;
    // stage 3: sum of squares and normalized point
    logic [2*CW-1:0]      p3_sum_reg;
    logic signed [NW-1:0] p3_nx_reg, p3_ny_reg, p3_nz_reg;
    // stage 4: squares of normalized x and y
    logic [2*CW-1:0]      p4_sum_reg;
    logic signed [NW-1:0] p4_nx_reg, p4_ny_reg, p4_nz_reg;
    logic [2*NW-3:0]      p4_sqx_reg, p4_sqy_reg;
    logic [NW-2:0]        mx_next, my_next;
    // stage 5: square-root operands
    logic [OPW-1:0]       p5_op_reg [2];
    logic signed [NW-1:0] p5_nx_reg, p5_ny_reg, p5_nz_reg;

    logic [OPW-1:0]       sq_op   [NW+1][2];
    logic [NW+1:0]        sq_rem  [NW+1][2];
    logic [NW-1:0]        sq_root [NW+1][2];
    logic signed [NW-1:0] sq_nx [NW+1];
    logic signed [NW-1:0] sq_ny [NW+1];
    logic signed [NW-1:0] sq_nz [NW+1];

    // CORDIC setup, lane 0 is theta, lane 1 is phi
    logic signed [CWD-1:0] pre_px_reg [2];
    logic signed [CWD-1:0] pre_py_reg [2];
    logic signed [AGW-1:0] pre_ang_reg [2];
    logic                  pre_fixed_reg [2];
    logic [CW-1:0]         pre_radius_reg;
    logic signed [CWD-1:0] px0 [2];
    logic signed [CWD-1:0] py0 [2];
    logic [NW-1:0]         rad_full;

    logic signed [CWD-1:0] cx  [CS+1][2];
    logic signed [CWD-1:0] cy  [CS+1][2];
    logic signed [AGW-1:0] ca  [CS+1][2];
    logic                  cf  [CS+1][2];
    logic [CW-1:0]         crad [CS+1];

    // output buffer
    logic                 out_valid_reg, skid_valid_reg;
    logic [CW-1:0]        out_r_reg, skid_r_reg;
    logic [AW-1:0]        out_t_reg, skid_t_reg, out_p_reg, skid_p_reg;
    logic [AW-1:0]        res_t, res_p;
    logic signed [AGW-1:0] t_clamp;
    logic [TURN_BITS:0]   t_sum, p_sum;
    logic                 new_item, out_take;

    assign en       = !skid_valid_reg;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NP-2:0], in_valid};
    end

    always_comb
    begin
        ax_next = coord_x[CW-1] ? CW'(-coord_x) : CW'(coord_x);
        ay_next = coord_y[CW-1] ? CW'(-coord_y) : CW'(coord_y);
        az_next = coord_z[CW-1] ? CW'(-coord_z) : CW'(coord_z);
        m_next  = ax_next;
        if (ay_next > m_next)
            m_next = ay_next;
        if (az_next > m_next)
            m_next = az_next;
    end

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (p1_m_reg[i])
                msb = 6'(i);
        end
        s_next = (msb >= 6'd29) ? 5'd0 : 5'(6'd29 - msb);
    end

    always_comb
    begin
        mx_next = p3_nx_reg[NW-1] ? (NW-1)'(-p3_nx_reg) : p3_nx_reg[NW-2:0];
        my_next = p3_ny_reg[NW-1] ? (NW-1)'(-p3_ny_reg) : p3_ny_reg[NW-2:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_x_reg   <= coord_x;
            p1_y_reg   <= coord_y;
            p1_z_reg   <= coord_z;
            p1_ax_reg  <= ax_next;
            p1_ay_reg  <= ay_next;
            p1_az_reg  <= az_next;
            p1_m_reg   <= m_next;

            p2_x_reg   <= p1_x_reg;
            p2_y_reg   <= p1_y_reg;
            p2_z_reg   <= p1_z_reg;
            p2_sqx_reg <= p1_ax_reg * p1_ax_reg;
            p2_sqy_reg <= p1_ay_reg * p1_ay_reg;
            p2_sqz_reg <= p1_az_reg * p1_az_reg;
            p2_s_reg   <= s_next;

            p3_sum_reg <= p2_sqx_reg + p2_sqy_reg + p2_sqz_reg;
            p3_nx_reg  <= NW'(p2_x_reg) <<< p2_s_reg;
            p3_ny_reg  <= NW'(p2_y_reg) <<< p2_s_reg;
            p3_nz_reg  <= NW'(p2_z_reg) <<< p2_s_reg;

            p4_sum_reg <= p3_sum_reg;
            p4_nx_reg  <= p3_nx_reg;
            p4_ny_reg  <= p3_ny_reg;
            p4_nz_reg  <= p3_nz_reg;
            p4_sqx_reg <= mx_next * mx_next;
            p4_sqy_reg <= my_next * my_next;

            p5_op_reg[0] <= OPW'(p4_sum_reg);
            p5_op_reg[1] <= OPW'(p4_sqx_reg) + OPW'(p4_sqy_reg);
            p5_nx_reg    <= p4_nx_reg;
            p5_ny_reg    <= p4_ny_reg;
            p5_nz_reg    <= p4_nz_reg;
        end
    end

    assign sq_op[0]      = p5_op_reg;
    assign sq_rem[0][0]  = '0;
    assign sq_rem[0][1]  = '0;
    assign sq_root[0][0] = '0;
    assign sq_root[0][1] = '0;
    assign sq_nx[0]      = p5_nx_reg;
    assign sq_ny[0]      = p5_ny_reg;
    assign sq_nz[0]      = p5_nz_reg;

    for (genvar k = 0; k < NW; k++)
    begin : g_sqrt
        c2s_sqrt_cell #(
            .NW(NW)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .op_in    (sq_op[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .nx_in    (sq_nx[k]),
            .ny_in    (sq_ny[k]),
            .nz_in    (sq_nz[k]),
            .op_out   (sq_op[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .nx_out   (sq_nx[k+1]),
            .ny_out   (sq_ny[k+1]),
            .nz_out   (sq_nz[k+1])
        );
    end

    always_comb
    begin
        // round to nearest: bump when the remainder exceeds the root
        rad_full = sq_root[NW][0] +
                   NW'(sq_rem[NW][0] > {2'b00, sq_root[NW][0]});
        px0[0] = CWD'(sq_nz[NW]);
        py0[0] = $signed({3'b000, sq_root[NW][1]});
        px0[1] = CWD'(sq_nx[NW]);
        py0[1] = CWD'(sq_ny[NW]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                pre_fixed_reg[l] <= (py0[l] == '0);
                pre_ang_reg[l]   <= px0[l][CWD-1] ? HALF : '0;
                pre_px_reg[l]    <= px0[l][CWD-1] ? -px0[l] : px0[l];
                pre_py_reg[l]    <= px0[l][CWD-1] ? -py0[l] : py0[l];
            end
            pre_radius_reg <= rad_full[CW-1:0];
        end
    end

    assign cx[0]   = pre_px_reg;
    assign cy[0]   = pre_py_reg;
    assign ca[0]   = pre_ang_reg;
    assign cf[0]   = pre_fixed_reg;
    assign crad[0] = pre_radius_reg;

    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        c2s_cordic_cell #(
            .CWD  (CWD),
            .AGW  (AGW),
            .STAGE(k),
            .RW   (CW)
        ) u_cell (
            .clk        (clk),
            .en         (en),
            .px_in      (cx[k]),
            .py_in      (cy[k]),
            .ang_in     (ca[k]),
            .fixed_in   (cf[k]),
            .radius_in  (crad[k]),
            .px_out     (cx[k+1]),
            .py_out     (cy[k+1]),
            .ang_out    (ca[k+1]),
            .fixed_out  (cf[k+1]),
            .radius_out (crad[k+1])
        );
    end

    always_comb
    begin
        // clamp theta drift into [0, pi]
        if (ca[CS][0][AGW-1])
            t_clamp = '0;
        else if (ca[CS][0] > HALF)
            t_clamp = HALF;
        else
            t_clamp = ca[CS][0];
        t_sum = {1'b0, t_clamp[TURN_BITS-1:0]} + RADD;
        p_sum = {1'b0, ca[CS][1][TURN_BITS-1:0]} + RADD;
        res_t = t_sum[SH +: AW];
        res_p = p_sum[SH +: AW];
    end

    assign new_item = v_reg[NP-1] && en;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg  <= skid_valid_reg || new_item;
            skid_valid_reg <= 1'b0;
        end
        else if (new_item)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_r_reg <= skid_r_reg;
                out_t_reg <= skid_t_reg;
                out_p_reg <= skid_p_reg;
            end
            else if (new_item)
            begin
                out_r_reg <= crad[CS];
                out_t_reg <= res_t;
                out_p_reg <= res_p;
            end
        end
        else if (new_item)
        begin
            // hold the result behind the stalled one
            skid_r_reg <= crad[CS];
            skid_t_reg <= res_t;
            skid_p_reg <= res_p;
        end
    end

    assign out_valid   = out_valid_reg;
    assign radius      = out_r_reg;
    assign polar_angle = out_t_reg;
    assign azimuth     = out_p_reg;

endmodule

// ===== hdl/c2s_checker.sv =====
`timescale 1ns / 1ps

module c2s_checker #(
    parameter int COORD_WIDTH   = 16,
    parameter int ANGLE_WIDTH   = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [COORD_WIDTH-1:0]        radius,
    input logic [ANGLE_WIDTH-1:0]        polar_angle,
    input logic [ANGLE_WIDTH-1:0]        azimuth
);

    localparam logic [ANGLE_WIDTH-1:0] PI_CODE = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(radius) && $stable(polar_angle) && $stable(azimuth))
        else $error("stalled result changed");

    // input stalls only while a result is waiting at the output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> polar_angle <= PI_CODE)
        else $error("polar angle beyond pi");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (radius == '0) |-> (polar_angle == '0) && (azimuth == '0))
        else $error("origin gave nonzero angles");

endmodule

bind cartesian_to_spherical_unit c2s_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH)
) u_c2s_checker (.*);

// ===== tb/cartesian_to_spherical_unit_checker.sv =====
`timescale 1ns / 1ps

module cartesian_to_spherical_unit_checker #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = c2s_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [COORD_WIDTH-1:0]        radius,
    input  logic [ANGLE_WIDTH-1:0]        polar_angle,
    input  logic [ANGLE_WIDTH-1:0]        azimuth,
    output int                            fail_count,
    output int                            pending
);

    import c2s_pkg::*;

    localparam longint HALF_TURN = 64'sd1 <<< 31;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] radius;
        logic [ANGLE_WIDTH-1:0] polar;
        logic [ANGLE_WIDTH-1:0] azim;
    } sphere_t;

    sphere_t expected_points[$];

    assign pending = expected_points.size();

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring rotation toward +x, angle in 2^-32 turn
    function automatic longint vector_angle(longint px, longint py);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (py == 0)
            return (px < 0) ? HALF_TURN : 0;
        if (px < 0)
        begin
            px = -px;
            py = -py;
            ang = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0)
            begin
                px += dx;
                py -= dy;
                ang += longint'(ATAN_TURNS[i]);
            end
            else
            begin
                px -= dx;
                py += dy;
                ang -= longint'(ATAN_TURNS[i]);
            end
        end
        return ang;
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] to_output_angle(longint unsigned ang);
        int sh;
        sh = 32 - ANGLE_WIDTH;
        if (sh == 0)
            return ANGLE_WIDTH'(ang);
        return ANGLE_WIDTH'((ang + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic sphere_t convert_point(longint x, longint y, longint z);
        sphere_t r;
        longint unsigned ax, ay, az, sum, root, m;
        longint nx, ny, nz, rxy, t, p;
        int s;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        sum = ax * ax + ay * ay + az * az;
        root = isqrt(sum);
        if (sum - root * root > root)
            root++;
        m = ax;
        if (ay > m)
            m = ay;
        if (az > m)
            m = az;
        r.radius = COORD_WIDTH'(root);
        r.polar = '0;
        r.azim = '0;
        if (m != 0)
        begin
            s = 0;
            while ((m << s) < (64'd1 << 29))
                s++;
            nx = x <<< s;
            ny = y <<< s;
            nz = z <<< s;
            ax = (nx < 0) ? -nx : nx;
            ay = (ny < 0) ? -ny : ny;
            rxy = longint'(isqrt(ax * ax + ay * ay));
            t = vector_angle(nz, rxy);
            if (t < 0)
                t = 0;
            if (t > HALF_TURN)
                t = HALF_TURN;
            r.polar = to_output_angle(t);
            if (nx != 0 || ny != 0)
            begin
                p = vector_angle(nx, ny);
                r.azim = to_output_angle(p & 64'hFFFF_FFFF);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        sphere_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_points.push_back(convert_point(coord_x, coord_y, coord_z));
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                    report_mismatch("unexpected result, radius", radius, 0);
                else
                begin
                    want = expected_points.pop_front();
                    if (radius !== want.radius)
                        report_mismatch("radius", radius, want.radius);
                    if (polar_angle !== want.polar)
                        report_mismatch("polar_angle", polar_angle, want.polar);
                    if (azimuth !== want.azim)
                        report_mismatch("azimuth", azimuth, want.azim);
                end
            end
        end
    end

endmodule

// ===== tb/cartesian_to_spherical_unit_test.sv =====
`timescale 1ns / 1ps

module cartesian_to_spherical_unit_test;
    import c2s_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int LATENCY = 7 + 31 + CORDIC_STAGES_DEF;
    localparam int RANDOM_POINTS = 450;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic signed [CW-1:0] coord_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CW-1:0] radius;
    logic [ANGLE_WIDTH_DEF-1:0] polar_angle;
    logic [ANGLE_WIDTH_DEF-1:0] azimuth;
    int fail_count;
    int pending;
    longint cycles = 0;
    bit hold_output = 0;
    bit calm = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cartesian_to_spherical_unit DUT (.*);

    cartesian_to_spherical_unit_checker checker_inst (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_output = 0;
            end
            else if (!calm && $urandom_range(3) == 0)
            begin
                n = $urandom_range(17, 1);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(20, 1);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        int gap;
        if (!calm && $urandom_range(4) == 0)
        begin
            gap = $urandom_range(17, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(5))
            0: return CW'($urandom_range(4) - 2);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2: return 16'(($urandom_range(511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [CW-1:0] edge_vals [6];
        int waited;
        edge_vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h8001};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // origin, axes, extremes
        send_point(0, 0, 0);
        send_point(0, 0, 5);
        send_point(0, 0, -16'sd5);
        send_point(0, 0, 16'h8000);
        send_point(7, 0, 3);
        send_point(-16'sd7, 0, 3);
        send_point(16'h8000, 0, 0);
        send_point(0, 16'h7FFF, 0);
        send_point(0, 16'h8000, 0);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(1, 16'hFFFF, 0);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        // a point just below the +x axis drives azimuth toward a full turn
        send_point(16'h7FFF, 16'hFFFF, 0);
        send_point(16'h7FFF, 1, 16'h8000);
        for (int i = 0; i < 6; i++)
            send_point(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6]);
        // hold the output while requests keep coming
        hold_output = 1;
        for (int i = 0; i < RANDOM_POINTS / 2; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        // pause until drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < RANDOM_POINTS / 3; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        calm = 1;
        for (int i = 0; i < RANDOM_POINTS / 6; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
